// File: sv/bhi_pkg.sv
package bhi_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int COORD_W = 32;
  localparam int HGT_W   = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int SUM_W   = PROD_W + 1;
  // |det| and |numerator| never exceed 2^65, so one bit less than the signed sum
  localparam int MAG_W   = SUM_W - 1;

  localparam int LIMB_W  = 32;
  localparam int MUL_LAT = 5;

  localparam logic signed [HGT_W-1:0] HGT_MAX = {1'b0, {(HGT_W-1){1'b1}}};
  localparam logic signed [HGT_W-1:0] HGT_MIN = {1'b1, {(HGT_W-1){1'b0}}};

  typedef struct packed {
    logic signed [DIFF_W-1:0] dh13;
    logic signed [DIFF_W-1:0] dh23;
    logic signed [HGT_W-1:0]  h3;
  } hgt_side_t;

  typedef struct packed {
    hgt_side_t hgt;
    logic      degen;
    logic      neg1;
    logic      neg2;
  } mid_side_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] h3;
    logic                    degen;
  } back_side_t;

endpackage

// File: sv/bhi_if.sv
interface bhi_query_if import bhi_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] first_x;
  logic signed [COORD_W-1:0] first_height;
  logic signed [COORD_W-1:0] first_z;
  logic signed [COORD_W-1:0] second_x;
  logic signed [COORD_W-1:0] second_height;
  logic signed [COORD_W-1:0] second_z;
  logic signed [COORD_W-1:0] third_x;
  logic signed [COORD_W-1:0] third_height;
  logic signed [COORD_W-1:0] third_z;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_z;

  modport source (
    output valid, first_x, first_height, first_z, second_x, second_height, second_z,
           third_x, third_height, third_z, query_x, query_z,
    input  ready
  );

  modport sink (
    input  valid, first_x, first_height, first_z, second_x, second_height, second_z,
           third_x, third_height, third_z, query_x, query_z,
    output ready
  );
endinterface

interface bhi_result_if import bhi_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [HGT_W-1:0] height;
  logic                    degenerate;

  modport source (output valid, height, degenerate, input ready);
  modport sink (input valid, height, degenerate, output ready);
endinterface

// File: sv/bhi_mul.sv
module bhi_mul import bhi_pkg::*; #(
  parameter int AW = DIFF_W,
  parameter int BW = DIFF_W
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int PW = AW + BW;
  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;

  logic [AW-1:0]        a_abs;
  logic [BW-1:0]        b_abs;
  logic [NA*LIMB_W-1:0] amag;
  logic [NB*LIMB_W-1:0] bmag;
  logic                 neg1, neg2, neg3, neg4;
  logic [2*LIMB_W-1:0]  pp [NA][NB];
  logic [PW-1:0]        row_sum [NB];
  logic [PW-1:0]        row [NB];
  logic [PW-1:0]        total;
  logic [PW-1:0]        mag;

  // magnitude of the most negative value is its own bit pattern read unsigned
  assign a_abs = a[AW-1] ? -a : a;
  assign b_abs = b[BW-1] ? -b : b;

  always_comb begin
    for (int j = 0; j < NB; j++) begin
      row_sum[j] = '0;
      for (int i = 0; i < NA; i++) begin
        row_sum[j] = row_sum[j] + (PW'(pp[i][j]) << (LIMB_W * i));
      end
    end
  end

  always_comb begin
    total = '0;
    for (int j = 0; j < NB; j++) begin
      total = total + (row[j] << (LIMB_W * j));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      amag <= (NA*LIMB_W)'(a_abs);
      bmag <= (NB*LIMB_W)'(b_abs);
      neg1 <= a[AW-1] ^ b[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp[i][j] <= amag[LIMB_W*i +: LIMB_W] * bmag[LIMB_W*j +: LIMB_W];
        end
      end
      neg2 <= neg1;
      row  <= row_sum;
      neg3 <= neg2;
      mag  <= total;
      neg4 <= neg3;
      p    <= signed'(neg4 ? -mag : mag);
    end
  end

endmodule

// File: sv/bhi_div.sv
module bhi_div import bhi_pkg::*; #(
  parameter int NW = MAG_W + FRAC_BITS_DEF,
  parameter int DW = MAG_W
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num_a,
  input  logic [NW-1:0] num_b,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo_a,
  output logic [NW-1:0] quo_b
);

  // per stage: partial remainder, and numerator bits still to enter with
  // quotient bits shifting in from the bottom
  logic [DW-1:0] rem_a [NW-1];
  logic [DW-1:0] rem_b [NW-1];
  logic [DW-1:0] den_q [NW-1];
  logic [NW-1:0] nq_a  [NW];
  logic [NW-1:0] nq_b  [NW];

  for (genvar k = 0; k < NW; k++) begin : g_stage
    logic [DW-1:0] rin_a, rin_b, din;
    logic [NW-1:0] nin_a, nin_b;
    logic [DW:0]   sh_a, sh_b, df_a, df_b;

    if (k == 0) begin : g_first
      assign rin_a = '0;
      assign rin_b = '0;
      assign din   = den;
      assign nin_a = num_a;
      assign nin_b = num_b;
    end else begin : g_next
      assign rin_a = rem_a[k-1];
      assign rin_b = rem_b[k-1];
      assign din   = den_q[k-1];
      assign nin_a = nq_a[k-1];
      assign nin_b = nq_b[k-1];
    end

    assign sh_a = {rin_a, nin_a[NW-1]};
    assign sh_b = {rin_b, nin_b[NW-1]};
    assign df_a = sh_a - {1'b0, din};
    assign df_b = sh_b - {1'b0, din};

    always_ff @(posedge clk) begin
      if (en) begin
        nq_a[k] <= {nin_a[NW-2:0], ~df_a[DW]};
        nq_b[k] <= {nin_b[NW-2:0], ~df_b[DW]};
      end
    end

    if (k < NW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          // keep the shifted remainder when the trial subtract goes negative
          rem_a[k] <= df_a[DW] ? sh_a[DW-1:0] : df_a[DW-1:0];
          rem_b[k] <= df_b[DW] ? sh_b[DW-1:0] : df_b[DW-1:0];
          den_q[k] <= din;
        end
      end
    end
  end

  assign quo_a = nq_a[NW-1];
  assign quo_b = nq_b[NW-1];

endmodule

// File: sv/barycentric_height_interp.sv
// The restoring divider resolves one quotient bit per stage over 66 + FRAC_BITS stages.
// Throughput: one item per cycle; ready drops only while the output skid entry is full.
// Reset (rst, synchronous): clears every valid bit, including those of the output and skid entries;
// datapath registers are not reset.
module barycentric_height_interp import bhi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  bhi_query_if.sink           query,
  bhi_result_if.source        result
);

  localparam int NUM_W   = MAG_W + FRAC_BITS;
  localparam int QL_W    = NUM_W + 1;
  localparam int WP_W    = QL_W + DIFF_W;
  localparam int S_W     = WP_W + 2;
  localparam int DIV_LAT = NUM_W;
  localparam int TOP_LO  = FRAC_BITS + HGT_W - 1;

  logic en;
  logic push;

  // input stage: coordinate and height differences
  logic                     v1;
  logic signed [DIFF_W-1:0] dz23, dx32, dx13, dz13, dz31, qdx, qdz;
  hgt_side_t                side1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= query.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dz23       <= DIFF_W'(query.second_z) - DIFF_W'(query.third_z);
      dx32       <= DIFF_W'(query.third_x) - DIFF_W'(query.second_x);
      dx13       <= DIFF_W'(query.first_x) - DIFF_W'(query.third_x);
      dz13       <= DIFF_W'(query.first_z) - DIFF_W'(query.third_z);
      dz31       <= DIFF_W'(query.third_z) - DIFF_W'(query.first_z);
      qdx        <= DIFF_W'(query.query_x) - DIFF_W'(query.third_x);
      qdz        <= DIFF_W'(query.query_z) - DIFF_W'(query.third_z);
      side1.dh13 <= DIFF_W'(query.first_height) - DIFF_W'(query.third_height);
      side1.dh23 <= DIFF_W'(query.second_height) - DIFF_W'(query.third_height);
      side1.h3   <= query.third_height;
    end
  end

  // cross products for determinant and both weight numerators
  logic signed [PROD_W-1:0] pm [6];

  bhi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul_det_a (
    .clk(clk), .en(en), .a(dz23), .b(dx13), .p(pm[0]));
  bhi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul_det_b (
    .clk(clk), .en(en), .a(dx32), .b(dz13), .p(pm[1]));
  bhi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul_n1_a (
    .clk(clk), .en(en), .a(dz23), .b(qdx), .p(pm[2]));
  bhi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul_n1_b (
    .clk(clk), .en(en), .a(dx32), .b(qdz), .p(pm[3]));
  bhi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul_n2_a (
    .clk(clk), .en(en), .a(dz31), .b(qdx), .p(pm[4]));
  bhi_mul #(.AW(DIFF_W), .BW(DIFF_W)) u_mul_n2_b (
    .clk(clk), .en(en), .a(dx13), .b(qdz), .p(pm[5]));

  logic [MUL_LAT-1:0] fv;
  hgt_side_t          fs [MUL_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else if (en) begin
      fv <= {fv[MUL_LAT-2:0], v1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fs[0] <= side1;
      for (int k = 1; k < MUL_LAT; k++) begin
        fs[k] <= fs[k-1];
      end
    end
  end

  // sums of products
  logic                    v7;
  logic signed [SUM_W-1:0] det, n1, n2;
  hgt_side_t               side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= fv[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det   <= SUM_W'(pm[0]) + SUM_W'(pm[1]);
      n1    <= SUM_W'(pm[2]) + SUM_W'(pm[3]);
      n2    <= SUM_W'(pm[4]) + SUM_W'(pm[5]);
      side7 <= fs[MUL_LAT-1];
    end
  end

  // split into sign and magnitude for the divider
  logic [SUM_W-1:0] det_abs, n1_abs, n2_abs;
  logic             v8;
  logic [MAG_W-1:0] dmag, n1mag, n2mag;
  mid_side_t        side8;

  assign det_abs = det[SUM_W-1] ? -det : det;
  assign n1_abs  = n1[SUM_W-1] ? -n1 : n1;
  assign n2_abs  = n2[SUM_W-1] ? -n2 : n2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dmag        <= det_abs[MAG_W-1:0];
      n1mag       <= n1_abs[MAG_W-1:0];
      n2mag       <= n2_abs[MAG_W-1:0];
      side8.hgt   <= side7;
      side8.degen <= (det == '0);
      side8.neg1  <= n1[SUM_W-1] ^ det[SUM_W-1];
      side8.neg2  <= n2[SUM_W-1] ^ det[SUM_W-1];
    end
  end

  logic [NUM_W-1:0] quo_a, quo_b;

  bhi_div #(.NW(NUM_W), .DW(MAG_W)) u_div (
    .clk   (clk),
    .en    (en),
    .num_a ({n1mag, {FRAC_BITS{1'b0}}}),
    .num_b ({n2mag, {FRAC_BITS{1'b0}}}),
    .den   (dmag),
    .quo_a (quo_a),
    .quo_b (quo_b)
  );

  logic [DIV_LAT-1:0] dv;
  mid_side_t          ds [DIV_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= '0;
    end else if (en) begin
      dv <= {dv[DIV_LAT-2:0], v8};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ds[0] <= side8;
      for (int k = 1; k < DIV_LAT; k++) begin
        ds[k] <= ds[k-1];
      end
    end
  end

  // signed weights, truncated toward zero
  logic [QL_W-1:0]         qa_ext, qb_ext;
  logic                    v9;
  logic signed [QL_W-1:0]  l1, l2;
  logic signed [DIFF_W-1:0] dh13_9, dh23_9;
  back_side_t              side9;

  assign qa_ext = QL_W'(quo_a);
  assign qb_ext = QL_W'(quo_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (en) begin
      v9 <= dv[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1          <= signed'(ds[DIV_LAT-1].neg1 ? -qa_ext : qa_ext);
      l2          <= signed'(ds[DIV_LAT-1].neg2 ? -qb_ext : qb_ext);
      dh13_9      <= ds[DIV_LAT-1].hgt.dh13;
      dh23_9      <= ds[DIV_LAT-1].hgt.dh23;
      side9.h3    <= ds[DIV_LAT-1].hgt.h3;
      side9.degen <= ds[DIV_LAT-1].degen;
    end
  end

  // l1*h1 + l2*h2 + l3*h3 folded to l1*(h1-h3) + l2*(h2-h3) + h3*2^F
  logic signed [WP_W-1:0] pb [2];

  bhi_mul #(.AW(QL_W), .BW(DIFF_W)) u_mul_w1 (
    .clk(clk), .en(en), .a(l1), .b(dh13_9), .p(pb[0]));
  bhi_mul #(.AW(QL_W), .BW(DIFF_W)) u_mul_w2 (
    .clk(clk), .en(en), .a(l2), .b(dh23_9), .p(pb[1]));

  logic [MUL_LAT-1:0] bv;
  back_side_t         bs [MUL_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      bv <= '0;
    end else if (en) begin
      bv <= {bv[MUL_LAT-2:0], v9};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bs[0] <= side9;
      for (int k = 1; k < MUL_LAT; k++) begin
        bs[k] <= bs[k-1];
      end
    end
  end

  logic                   v15;
  logic signed [WP_W:0]   sum1;
  back_side_t             side15;

  always_ff @(posedge clk) begin
    if (rst) begin
      v15 <= 1'b0;
    end else if (en) begin
      v15 <= bv[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum1   <= (WP_W+1)'(pb[0]) + (WP_W+1)'(pb[1]);
      side15 <= bs[MUL_LAT-1];
    end
  end

  // h3 * 2^F plus the rounding half: the low bits are free, so concatenate
  logic signed [HGT_W+FRAC_BITS-1:0] hterm;
  logic                              v16;
  logic signed [S_W-1:0]             s2;
  logic                              degen16;

  assign hterm = {side15.h3, 1'b1, {(FRAC_BITS-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v16 <= 1'b0;
    end else if (en) begin
      v16 <= v15;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2      <= S_W'(sum1) + S_W'(hterm);
      degen16 <= side15.degen;
    end
  end

  // scale down and saturate, or give zero for a degenerate triangle
  logic [S_W-TOP_LO-1:0]   top_bits;
  logic                    fits;
  logic signed [HGT_W-1:0] height_next;

  assign top_bits = s2[S_W-1:TOP_LO];
  assign fits     = (&top_bits) | ~(|top_bits);

  always_comb begin
    if (degen16) begin
      height_next = '0;
    end else if (fits) begin
      height_next = s2[TOP_LO:FRAC_BITS];
    end else if (s2[S_W-1]) begin
      height_next = HGT_MIN;
    end else begin
      height_next = HGT_MAX;
    end
  end

  // output register with one skid entry; the pipeline freezes while the skid is full
  logic                    ovalid, svalid;
  logic signed [HGT_W-1:0] oheight, sheight;
  logic                    odeg, sdeg;

  assign en   = ~svalid;
  assign push = v16 & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      svalid <= 1'b0;
    end else if (!ovalid || result.ready) begin
      if (svalid) begin
        ovalid <= 1'b1;
        svalid <= 1'b0;
      end else begin
        ovalid <= push;
      end
    end else if (push) begin
      svalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ovalid || result.ready) begin
      if (svalid) begin
        oheight <= sheight;
        odeg    <= sdeg;
      end else if (push) begin
        oheight <= height_next;
        odeg    <= degen16;
      end
    end else if (push) begin
      sheight <= height_next;
      sdeg    <= degen16;
    end
  end

  assign query.ready       = en;
  assign result.valid      = ovalid;
  assign result.height     = oheight;
  assign result.degenerate = odeg;

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    svalid |-> ovalid)
    else $error("skid entry full while output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(svalid) |-> $past(ovalid && !result.ready))
    else $error("skid entry filled without a stalled output");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (ovalid && odeg) |-> (oheight == '0))
    else $error("degenerate result with nonzero height");
`endif

endmodule

// File: sim/barycentric_height_interp_tb.sv
module barycentric_height_interp_tb import bhi_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int ITEMS_PER_PHASE = 510;
  localparam int SETTLE_CYCLES = 82 + FRAC + 40;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] first_x;
    logic signed [COORD_W-1:0] first_height;
    logic signed [COORD_W-1:0] first_z;
    logic signed [COORD_W-1:0] second_x;
    logic signed [COORD_W-1:0] second_height;
    logic signed [COORD_W-1:0] second_z;
    logic signed [COORD_W-1:0] third_x;
    logic signed [COORD_W-1:0] third_height;
    logic signed [COORD_W-1:0] third_z;
    logic signed [COORD_W-1:0] query_x;
    logic signed [COORD_W-1:0] query_z;
  } query_item_t;

  typedef struct packed {
    logic signed [HGT_W-1:0] height;
    logic                    degenerate;
  } height_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic        q_valid    = 1'b0;
  query_item_t q_drive    = '0;
  logic        res_ready  = 1'b0;
  logic        query_took = 1'b0;

  query_item_t pending_queries[$];
  height_res_t expected_heights[$];

  int send_idle = 34;
  int recv_idle = 81;
  int n_errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_directed = 0;
  int n_degen = 0;
  int n_sat = 0;

  bhi_query_if  query_bus();
  bhi_result_if result_bus();

  assign query_bus.valid         = q_valid;
  assign query_bus.first_x       = q_drive.first_x;
  assign query_bus.first_height  = q_drive.first_height;
  assign query_bus.first_z       = q_drive.first_z;
  assign query_bus.second_x      = q_drive.second_x;
  assign query_bus.second_height = q_drive.second_height;
  assign query_bus.second_z      = q_drive.second_z;
  assign query_bus.third_x       = q_drive.third_x;
  assign query_bus.third_height  = q_drive.third_height;
  assign query_bus.third_z       = q_drive.third_z;
  assign query_bus.query_x       = q_drive.query_x;
  assign query_bus.query_z       = q_drive.query_z;
  assign result_bus.ready        = res_ready;

  barycentric_height_interp dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_bus),
    .result (result_bus)
  );

  always #6 clk = ~clk;

  // Exact barycentric interpolation on wide signed values.
  function automatic height_res_t interp_height(query_item_t q);
    wide_t x1, z1, x2, z2, x3, z3, h1, h2, h3, qx, qz;
    wide_t dz23, dx32, dx13, dz13, dz31, qdx, qdz;
    wide_t det, n1, n2, l1, l2, l3, s;
    height_res_t r;
    x1 = $signed(q.first_x);   h1 = $signed(q.first_height);  z1 = $signed(q.first_z);
    x2 = $signed(q.second_x);  h2 = $signed(q.second_height); z2 = $signed(q.second_z);
    x3 = $signed(q.third_x);   h3 = $signed(q.third_height);  z3 = $signed(q.third_z);
    qx = $signed(q.query_x);   qz = $signed(q.query_z);
    dz23 = z2 - z3;
    dx32 = x3 - x2;
    dx13 = x1 - x3;
    dz13 = z1 - z3;
    dz31 = z3 - z1;
    qdx  = qx - x3;
    qdz  = qz - z3;
    det = dz23 * dx13 + dx32 * dz13;
    if (det == 0) begin
      r.height = '0;
      r.degenerate = 1'b1;
      return r;
    end
    n1 = (dz23 * qdx + dx32 * qdz) <<< FRAC;
    n2 = (dz31 * qdx + dx13 * qdz) <<< FRAC;
    l1 = n1 / det;
    l2 = n2 / det;
    l3 = wide_t'(ONE) - l1 - l2;
    s = l1 * h1 + l2 * h2 + l3 * h3 + wide_t'(ONE >>> 1);
    // floor after adding one half: ties round toward plus infinity
    s = s >>> FRAC;
    if (s > wide_t'(HGT_MAX))
      r.height = HGT_MAX;
    else if (s < wide_t'(HGT_MIN))
      r.height = HGT_MIN;
    else
      r.height = s[31:0];
    r.degenerate = 1'b0;
    return r;
  endfunction

  function automatic query_item_t make_query(
    input logic signed [31:0] x1, h1, z1, x2, h2, z2, x3, h3, z3, qx, qz
  );
    return query_item_t'{x1, h1, z1, x2, h2, z2, x3, h3, z3, qx, qz};
  endfunction

  // Random value with up to the given number of magnitude bits, random sign.
  function automatic logic signed [31:0] rand_coord(int unsigned bits);
    logic signed [31:0] v;
    v = $urandom >> (32 - bits);
    if ($urandom_range(1) == 1)
      v = -v;
    return v;
  endfunction

  function automatic logic signed [31:0] pick_extreme();
    case ($urandom_range(5))
      0:       return HGT_MIN;
      1:       return HGT_MAX;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4:       return 32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic query_item_t rand_query();
    query_item_t q;
    int unsigned kind, span;
    int k;
    logic signed [31:0] dx, dz;
    kind = $urandom_range(99);
    span = $urandom_range(8, 26);
    q.first_x       = rand_coord(span);
    q.first_z       = rand_coord(span);
    q.second_x      = rand_coord(span);
    q.second_z      = rand_coord(span);
    q.third_x       = rand_coord(span);
    q.third_z       = rand_coord(span);
    q.first_height  = rand_coord($urandom_range(4, 32));
    q.second_height = rand_coord($urandom_range(4, 32));
    q.third_height  = rand_coord($urandom_range(4, 32));
    q.query_x       = q.first_x + rand_coord(span + 1);
    q.query_z       = q.first_z + rand_coord(span + 1);
    if (kind < 20) begin
      q = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind < 30) begin
      // zero-area triangles
      case ($urandom_range(2))
        0: begin
          q.second_x = q.first_x;
          q.second_z = q.first_z;
        end
        1: begin
          dx = rand_coord(12);
          dz = rand_coord(12);
          k = int'($urandom_range(7)) - 3;
          q.second_x = q.first_x + dx;
          q.second_z = q.first_z + dz;
          q.third_x  = q.first_x + k * dx;
          q.third_z  = q.first_z + k * dz;
        end
        default: begin
          q.third_x = q.first_x;
          q.third_z = q.first_z;
        end
      endcase
    end else if (kind < 45) begin
      case ($urandom_range(3))
        0: begin q.query_x = q.first_x;  q.query_z = q.first_z;  end
        1: begin q.query_x = q.second_x; q.query_z = q.second_z; end
        2: begin q.query_x = q.third_x;  q.query_z = q.third_z;  end
        default: begin
          q.query_x = (q.first_x + q.second_x + q.third_x) / 3;
          q.query_z = (q.first_z + q.second_z + q.third_z) / 3;
        end
      endcase
    end else if (kind < 55) begin
      q = {pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
           pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
           pick_extreme(), pick_extreme(), pick_extreme()};
    end
    return q;
  endfunction

  task automatic report_mismatch(string what, logic signed [31:0] got,
                                 logic signed [31:0] want);
    $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
    n_errors++;
  endtask

  // Driver: present the next pending query after each transfer, and drive result ready at random.
  always @(negedge clk) begin
    if (rst) begin
      q_valid   <= 1'b0;
      res_ready <= 1'b0;
    end else begin
      if (!q_valid || query_took) begin
        if (pending_queries.size() != 0 && $urandom_range(99) >= send_idle) begin
          q_valid <= 1'b1;
          q_drive <= pending_queries.pop_front();
        end else begin
          q_valid <= 1'b0;
        end
      end
      res_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Monitor: predict on each query transfer, check on each result transfer.
  always @(posedge clk) begin : monitor
    height_res_t want;
    if (rst) begin
      query_took <= 1'b0;
    end else begin
      query_took <= q_valid && query_bus.ready;
      if (q_valid && query_bus.ready) begin
        expected_heights.push_back(interp_height(q_drive));
        n_sent++;
      end
      if (result_bus.valid && res_ready) begin
        if (expected_heights.size() == 0) begin
          report_mismatch("unexpected result", result_bus.height, 32'sd0);
        end else begin
          want = expected_heights.pop_front();
          if (result_bus.height !== want.height)
            report_mismatch("height", result_bus.height, want.height);
          if (result_bus.degenerate !== want.degenerate)
            report_mismatch("degenerate", 32'(result_bus.degenerate), 32'(want.degenerate));
          n_checked++;
          if (want.degenerate)
            n_degen++;
          else if (want.height == HGT_MAX || want.height == HGT_MIN)
            n_sat++;
        end
      end
    end
  end

  initial begin : stimulus
    int p, i;
    // unit right triangle, inside, at each vertex, and clockwise
    pending_queries.push_back(make_query(0, 5*ONE, 0, ONE, 7*ONE, 0, 0, -3*ONE, ONE,
                                         ONE/4, ONE/4));
    pending_queries.push_back(make_query(0, 5*ONE, 0, ONE, 7*ONE, 0, 0, -3*ONE, ONE, 0, 0));
    pending_queries.push_back(make_query(0, 5*ONE, 0, ONE, 7*ONE, 0, 0, -3*ONE, ONE, ONE, 0));
    pending_queries.push_back(make_query(0, 5*ONE, 0, ONE, 7*ONE, 0, 0, -3*ONE, ONE, 0, ONE));
    pending_queries.push_back(make_query(0, 5*ONE, 0, 0, -3*ONE, ONE, ONE, 7*ONE, 0,
                                         ONE/3, ONE/5));
    // half-LSB ties on an edge midpoint, both signs
    pending_queries.push_back(make_query(0, 0, 0, 2*ONE, 1, 0, 0, 0, 2*ONE, ONE, 0));
    pending_queries.push_back(make_query(0, 0, 0, 2*ONE, -1, 0, 0, 0, 2*ONE, ONE, 0));
    // zero area: all zero, collinear, repeated vertex, all ones
    pending_queries.push_back(make_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_queries.push_back(make_query(0, ONE, 0, ONE, 2*ONE, ONE, 3*ONE, ONE, 3*ONE,
                                         ONE, 0));
    pending_queries.push_back(make_query(ONE, 9*ONE, 2*ONE, ONE, 4*ONE, 2*ONE, 5*ONE, 0, 0,
                                         ONE, ONE));
    pending_queries.push_back(make_query(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1));
    // full-range coordinates and heights
    pending_queries.push_back(make_query(HGT_MIN, HGT_MAX, HGT_MIN, HGT_MAX, HGT_MAX, HGT_MIN,
                                         HGT_MIN, HGT_MAX, HGT_MAX, HGT_MAX, HGT_MAX));
    pending_queries.push_back(make_query(HGT_MIN, HGT_MIN, HGT_MIN, HGT_MAX, HGT_MIN, HGT_MIN,
                                         HGT_MIN, HGT_MIN, HGT_MAX, HGT_MAX, HGT_MAX));
    pending_queries.push_back(make_query(HGT_MIN, HGT_MAX, HGT_MIN, HGT_MAX, HGT_MIN, HGT_MIN,
                                         HGT_MIN, 0, HGT_MAX, HGT_MIN, HGT_MIN));
    pending_queries.push_back(make_query(HGT_MAX, HGT_MAX, HGT_MAX, HGT_MIN, HGT_MIN, HGT_MAX,
                                         HGT_MAX, 0, HGT_MIN, 0, 0));
    // one-LSB triangle with a far query: huge weights
    pending_queries.push_back(make_query(0, HGT_MAX, 0, 1, HGT_MIN, 0, 0, 0, 1,
                                         HGT_MAX, HGT_MAX));
    pending_queries.push_back(make_query(0, HGT_MAX, 0, 1, HGT_MIN, 0, 0, 0, 1,
                                         HGT_MIN, HGT_MAX));
    // query far outside: saturate high, then low
    pending_queries.push_back(make_query(0, 0, 0, ONE, 100*ONE, 0, 0, 0, ONE, 30000*ONE, 0));
    pending_queries.push_back(make_query(0, 0, 0, ONE, -100*ONE, 0, 0, 0, ONE, 30000*ONE, 0));
    // mixed extreme heights at the centroid
    pending_queries.push_back(make_query(0, HGT_MAX, 0, 3*ONE, HGT_MIN, 0, 0, 0, 3*ONE,
                                         ONE, ONE));
    n_directed = pending_queries.size();

    for (p = 0; p < 3; p++) begin
      case (p)
        0:       begin send_idle = 34; recv_idle = 81; end
        1:       begin send_idle = 81; recv_idle = 34; end
        default: begin send_idle = 0;  recv_idle = 0;  end
      endcase
      for (i = 0; i < ITEMS_PER_PHASE; i++)
        pending_queries.push_back(rand_query());
      if (p == 0) begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst = 1'b0;
      end
      while (pending_queries.size() != 0) @(posedge clk);
    end

    while (q_valid) @(posedge clk);
    while (expected_heights.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d queries (%0d directed) under three stall patterns; %0d results checked.",
             n_sent, n_directed, n_checked);
    $display("Zero-area triangles: %0d, saturated heights: %0d, mismatches: %0d.",
             n_degen, n_sat, n_errors);
    if (n_errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin : watchdog
    #2880000;
    $display("Timed out with %0d results outstanding", expected_heights.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: barycentric_height_interp.f
sv/bhi_pkg.sv
sv/bhi_if.sv
sv/bhi_mul.sv
sv/bhi_div.sv
sv/barycentric_height_interp.sv
sim/barycentric_height_interp_tb.sv
